// ===== rtl/core/matrix_inverse_3x3_macros.svh =====
// ---------------------------------------------------------------------------
// matrix_inverse_3x3 assertion macros
// Shared concurrent assertion forms for the matrix inverse block.
// ---------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// same-cycle implication
`define MI3_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mi3_pkg.sv =====
// ---------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse block.
// ---------------------------------------------------------------------------
package mi3_pkg;

    localparam int ELEM_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int THR_W         = 40;
    localparam logic [THR_W-1:0] THR_RESET = 40'd281475;

    // cofactor k = e[A]*e[B] - e[C]*e[D], row-major element indexes
    localparam int CF_A [0:8] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
    localparam int CF_B [0:8] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
    localparam int CF_C [0:8] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
    localparam int CF_D [0:8] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

    typedef struct packed {
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv00;
        logic signed [ELEM_W-1:0] inv01;
        logic signed [ELEM_W-1:0] inv02;
        logic signed [ELEM_W-1:0] inv10;
        logic signed [ELEM_W-1:0] inv11;
        logic signed [ELEM_W-1:0] inv12;
        logic signed [ELEM_W-1:0] inv20;
        logic signed [ELEM_W-1:0] inv21;
        logic signed [ELEM_W-1:0] inv22;
        logic                     singular;
    } t_out;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_det_ctl;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [ELEM_W-1:0] q;
    } t_lane_res;

endpackage

// ===== rtl/core/mi3_div_lane.sv =====
// ---------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider lane, one quotient bit per stage, saturating.
// ---------------------------------------------------------------------------
module mi3_div_lane #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic                                          i_zero,
    input  logic                                          i_neg,
    input  logic [2*mi3_pkg::ELEM_W+2*FRAC_BITS-1:0]      i_num,
    input  logic [3*mi3_pkg::ELEM_W:0]                    i_den,
    output mi3_pkg::t_lane_res                            o_res
);
    localparam int W     = mi3_pkg::ELEM_W;
    localparam int DEN_W = 3 * W + 1;
    localparam int XW    = DEN_W + W + 1;
    localparam logic [W-1:0] HALF = W'(1) << (W - 1);
    localparam logic [W-1:0] MAXP = HALF - W'(1);

    logic [XW-1:0]    r_rem  [0:W];
    logic [DEN_W-1:0] r_den  [0:W];
    logic [W-1:0]     r_q    [0:W];
    logic             r_ovf  [0:W];
    logic             r_zero [0:W];
    logic             r_neg  [0:W];
    logic             r_vld  [0:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= W; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= W; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // quotient at or above 2^W saturates whatever the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= XW'(i_num);
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= XW'(i_num) >= (XW'(i_den) << W);
            r_zero[0] <= i_zero;
            r_neg[0]  <= i_neg;
        end
    end

    for (genvar s = 1; s <= W; s++) begin : g_stage
        localparam int B = W - s;
        logic [XW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = XW'(r_den[s-1]) << B;
        assign w_ge = r_rem[s-1] >= w_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? r_rem[s-1] - w_sh : r_rem[s-1];
                r_q[s]    <= r_q[s-1] | (w_ge ? (W'(1) << B) : W'(0));
                r_den[s]  <= r_den[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_zero[s] <= r_zero[s-1];
                r_neg[s]  <= r_neg[s-1];
            end
        end
    end

    always_comb begin
        o_res.valid = r_vld[W];
        o_res.zero  = r_zero[W];
        if (r_neg[W]) begin
            o_res.q = (r_ovf[W] || r_q[W] > HALF) ? HALF : W'(0) - r_q[W];
        end else begin
            o_res.q = (r_ovf[W] || r_q[W][W-1]) ? MAXP : r_q[W];
        end
    end

endmodule

// ===== rtl/core/mi3_det.sv =====
// ---------------------------------------------------------------------------
// mi3_det
// Cofactors, determinant, singular test and lane operands, five stages.
// ---------------------------------------------------------------------------
module mi3_det #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic signed [mi3_pkg::ELEM_W-1:0]             i_e [0:8],
    input  logic [mi3_pkg::THR_W-1:0]                     i_thr,
    output mi3_pkg::t_det_ctl                             o_ctl,
    output logic [3*mi3_pkg::ELEM_W:0]                    o_mag,
    output logic [2*mi3_pkg::ELEM_W+2*FRAC_BITS-1:0]      o_num [0:8],
    output logic                                          o_neg [0:8]
);
    localparam int W     = mi3_pkg::ELEM_W;
    localparam int CW    = 2 * W + 1;
    localparam int DW    = 3 * W + 2;
    localparam int DEN_W = 3 * W + 1;
    localparam int NUM_W = 2 * W + 2 * FRAC_BITS;

    logic [4:0] r_vld;

    logic signed [2*W-1:0] r_pa [0:8];
    logic signed [2*W-1:0] r_pb [0:8];
    logic signed [W-1:0]   r_e1 [0:2];
    logic signed [CW-1:0]  r_c2 [0:8];
    logic signed [W-1:0]   r_e2 [0:2];
    logic signed [CW-1:0]  r_c3 [0:8];
    logic signed [2*W:0]   r_pl [0:2];
    logic signed [2*W:0]   r_ph [0:2];
    logic signed [CW-1:0]  r_c4 [0:8];
    logic signed [DW-1:0]  r_det;

    logic                  r_sing;
    logic [DEN_W-1:0]      r_mag;
    logic [NUM_W-1:0]      r_num [0:8];
    logic                  r_neg [0:8];

    logic signed [W:0]     w_lo [0:2];
    logic signed [W:0]     w_hi [0:2];
    logic signed [DW-1:0]  w_det;
    logic signed [DW-1:0]  w_dabs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_lo[j] = $signed({1'b0, r_c2[3*j][W-1:0]});
            w_hi[j] = r_c2[3*j][CW-1:W];
        end
        w_det = '0;
        for (int j = 0; j < 3; j++) begin
            w_det = w_det + (DW'(r_ph[j]) <<< W) + DW'(r_pl[j]);
        end
        w_dabs = r_det[DW-1] ? -r_det : r_det;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_pa[k] <= i_e[mi3_pkg::CF_A[k]] * i_e[mi3_pkg::CF_B[k]];
                r_pb[k] <= i_e[mi3_pkg::CF_C[k]] * i_e[mi3_pkg::CF_D[k]];
                r_c2[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
                r_c3[k] <= r_c2[k];
                r_c4[k] <= r_c3[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_e1[j] <= i_e[j];
                r_e2[j] <= r_e1[j];
                // row 0 element times cofactor, split in two partial products
                r_pl[j] <= r_e2[j] * w_lo[j];
                r_ph[j] <= r_e2[j] * w_hi[j];
            end
            r_det  <= w_det;
            r_mag  <= w_dabs[DEN_W-1:0];
            r_sing <= (w_dabs == '0) || (w_dabs < DW'(i_thr));
            for (int k = 0; k < 9; k++) begin
                r_neg[k] <= r_c4[k][CW-1] ^ r_det[DW-1];
                r_num[k] <= NUM_W'(r_c4[k][CW-1] ? -r_c4[k] : r_c4[k]) << (2 * FRAC_BITS);
            end
        end
    end

    assign o_ctl.valid    = r_vld[4];
    assign o_ctl.singular = r_sing;
    assign o_mag          = r_mag;
    assign o_num          = r_num;
    assign o_neg          = r_neg;

endmodule

// ===== rtl/core/matrix_inverse_3x3.sv =====
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// Q16.16 3x3 inverse by adjugate over determinant, with singular detection.
// ---------------------------------------------------------------------------
// One matrix is taken every cycle while the output is not stalled. Each
// result passes five stages of cofactor and determinant products, then the
// nine divider lanes, which resolve one quotient bit per stage, and then the
// output register. A stall at the output holds the whole pipeline. The
// threshold register may be rewritten at any cycle but should change only
// while no matrix is in flight.
`include "matrix_inverse_3x3_macros.svh"

module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mi3_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mi3_pkg::t_out                 o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mi3_pkg::THR_W-1:0]     i_cfg_data
);
    localparam int W     = mi3_pkg::ELEM_W;
    localparam int NUM_W = 2 * W + 2 * FRAC_BITS;

    logic                        w_en;
    logic signed [W-1:0]         w_e [0:8];
    logic [mi3_pkg::THR_W-1:0]   r_thr;
    mi3_pkg::t_det_ctl           w_ctl;
    logic [3*W:0]                w_mag;
    logic [NUM_W-1:0]            w_num [0:8];
    logic                        w_neg [0:8];
    mi3_pkg::t_lane_res          w_res [0:8];
    logic [8:0]                  w_lvld;
    logic [W-1:0]                w_q [0:8];
    logic                        r_out_valid;
    mi3_pkg::t_out               r_out;

    assign w_en        = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    assign w_e[0] = i_in.m00;
    assign w_e[1] = i_in.m01;
    assign w_e[2] = i_in.m02;
    assign w_e[3] = i_in.m10;
    assign w_e[4] = i_in.m11;
    assign w_e[5] = i_in.m12;
    assign w_e[6] = i_in.m20;
    assign w_e[7] = i_in.m21;
    assign w_e[8] = i_in.m22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mi3_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_e     (w_e),
        .i_thr   (r_thr),
        .o_ctl   (w_ctl),
        .o_mag   (w_mag),
        .o_num   (w_num),
        .o_neg   (w_neg)
    );

    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_ctl.valid),
            .i_zero  (w_ctl.singular),
            .i_neg   (w_neg[k]),
            .i_num   (w_num[k]),
            .i_den   (w_mag),
            .o_res   (w_res[k])
        );
        assign w_lvld[k] = w_res[k].valid;
        assign w_q[k]    = w_res[k].zero ? W'(0) : w_res[k].q;
    end

    // merge the nine lanes into one result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_res[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.inv00    <= w_q[0];
            r_out.inv01    <= w_q[1];
            r_out.inv02    <= w_q[2];
            r_out.inv10    <= w_q[3];
            r_out.inv11    <= w_q[4];
            r_out.inv12    <= w_q[5];
            r_out.inv20    <= w_q[6];
            r_out.inv21    <= w_q[7];
            r_out.inv22    <= w_q[8];
            r_out.singular <= w_res[0].zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `MI3_ASSERT(a_lanes_aligned, i_clk, i_rst_n, 1'b1, ($countones(w_lvld) == 0) || (&w_lvld), "divider lanes out of step")
    `MI3_ASSERT(a_singular_zero, i_clk, i_rst_n, r_out_valid && r_out.singular, (r_out.inv00 == '0) && (r_out.inv11 == '0) && (r_out.inv22 == '0), "singular result not zeroed")
    `MI3_ASSERT(a_thr_reset, i_clk, i_rst_n, $rose(i_rst_n), r_thr == mi3_pkg::THR_RESET, "threshold not at reset value")
    `MI3_ASSERT_NEXT(a_lane_to_out, i_clk, i_rst_n, w_en && w_res[0].valid, r_out_valid, "lane result lost at merge")

endmodule
